// File: src/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// File: src/enms_pkg.sv
package enms_pkg;

    localparam int MAG_W      = 8;
    localparam int DIR_W      = 13;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int POS_W      = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;

    localparam int IMG_W_RESET = 1024;
    localparam int IMG_H_RESET = 1024;
    localparam int MIN_DIM     = 3;
    localparam int MAX_HEIGHT  = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // angles in 1/16 degree
    localparam logic signed [DIR_W:0] ANG_FULL = 14'sd5760;
    localparam logic signed [DIR_W:0] ANG_HALF = 14'sd2880;
    localparam logic signed [DIR_W:0] ANG_A    = 14'sd360;
    localparam logic signed [DIR_W:0] ANG_B    = 14'sd1080;
    localparam logic signed [DIR_W:0] ANG_C    = 14'sd1800;
    localparam logic signed [DIR_W:0] ANG_D    = 14'sd2520;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [DIR_W-1:0] direction;
        logic             frame_start;
    } in_t;

    typedef struct packed {
        logic [MAG_W-1:0] suppressed_value;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_last;
    } out_t;

    typedef struct packed {
        logic [MAG_W-1:0] top;
        logic [MAG_W-1:0] mid;
        logic [MAG_W-1:0] bot;
    } col_t;

    typedef struct packed {
        logic [MAG_W-1:0] upper;
        logic [MAG_W-1:0] mid;
        logic [DIR_W-1:0] dir;
    } line_t;

endpackage

// File: src/enms_line_ram.sv
module enms_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 29,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/enms_nms_core.sv
module enms_nms_core (
    input  enms_pkg::col_t                    left,
    input  enms_pkg::col_t                    centre,
    input  enms_pkg::col_t                    right,
    input  logic [enms_pkg::DIR_W-1:0]        centre_dir,
    output logic [enms_pkg::MAG_W-1:0]        value
);

    typedef enum logic [1:0] {
        DIR_HORZ,
        DIR_DIAG_POS,
        DIR_VERT,
        DIR_DIAG_NEG
    } dir_class_t;

    logic signed [enms_pkg::DIR_W:0] ang_raw;
    logic signed [enms_pkg::DIR_W:0] ang;
    dir_class_t                      cls;
    logic [enms_pkg::MAG_W-1:0]      n1;
    logic [enms_pkg::MAG_W-1:0]      n2;

    assign ang_raw = $signed({1'b0, centre_dir});
    assign ang     = (ang_raw > enms_pkg::ANG_HALF) ? ang_raw - enms_pkg::ANG_FULL : ang_raw;

    always_comb begin
        if ((ang > -enms_pkg::ANG_A && ang <= enms_pkg::ANG_A) ||
            ang > enms_pkg::ANG_D || ang <= -enms_pkg::ANG_D) begin
            cls = DIR_HORZ;
        end else if ((ang > -enms_pkg::ANG_B && ang <= -enms_pkg::ANG_A) ||
                     (ang > enms_pkg::ANG_C && ang <= enms_pkg::ANG_D)) begin
            cls = DIR_DIAG_POS;
        end else if ((ang > -enms_pkg::ANG_C && ang <= -enms_pkg::ANG_B) ||
                     (ang > enms_pkg::ANG_B && ang <= enms_pkg::ANG_C)) begin
            cls = DIR_VERT;
        end else begin
            cls = DIR_DIAG_NEG;
        end
    end

    always_comb begin
        case (cls)
            DIR_HORZ: begin
                n1 = left.mid;
                n2 = right.mid;
            end
            DIR_DIAG_POS: begin
                n1 = right.top;
                n2 = left.bot;
            end
            DIR_VERT: begin
                n1 = centre.top;
                n2 = centre.bot;
            end
            default: begin
                n1 = left.top;
                n2 = right.bot;
            end
        endcase
    end

    assign value = (centre.mid > n1 && centre.mid > n2) ? centre.mid : '0;

endmodule

// File: src/edge_non_maximum_suppression.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    enms_pkg::in_t
// m_        out        m_valid / m_ready    enms_pkg::out_t
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle sustained while m_ready is high; s_ data reaches m_ via both stages.
// Input stage: position counters and the line RAM read; result stage: window,
// direction compare and the output register. Border pixels give no m_ transfer.
// aresetn (synchronous, active low) clears counters, window and valids; the
// line RAM holds no reset. s_ready is high while the input stage is empty or
// can move into the result register; stalled m_ backs up after one more pixel.
`include "assert_macros.svh"

module edge_non_maximum_suppression #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  enms_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output enms_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [enms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [enms_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int PW        = enms_pkg::POS_W;
    localparam int RST_WIDTH = (enms_pkg::IMG_W_RESET > MAX_WIDTH) ?
                               MAX_WIDTH : enms_pkg::IMG_W_RESET;
    localparam logic [PW-1:0] MAX_W_P = PW'(MAX_WIDTH);
    localparam logic [PW-1:0] MAX_H_P = PW'(enms_pkg::MAX_HEIGHT);
    localparam logic [PW-1:0] MIN_P   = PW'(enms_pkg::MIN_DIM);
    localparam logic [PW-1:0] ONE_P   = PW'(1);
    localparam logic [PW-1:0] TWO_P   = PW'(2);

    // configuration
    logic [PW-1:0] weff_reg;
    logic [PW-1:0] heff_reg;
    logic [PW-1:0] raw_w;
    logic [PW-1:0] raw_h;
    logic [PW-1:0] clamp_w;
    logic [PW-1:0] clamp_h;

    assign cfg_ready = 1'b1;
    assign raw_w = PW'(cfg_data[enms_pkg::IMG_W_BITS-1:0]);
    assign raw_h = PW'(cfg_data[enms_pkg::IMG_H_BITS-1:0]);
    assign clamp_w = (raw_w < MIN_P) ? MIN_P : ((raw_w > MAX_W_P) ? MAX_W_P : raw_w);
    assign clamp_h = (raw_h < MIN_P) ? MIN_P : ((raw_h > MAX_H_P) ? MAX_H_P : raw_h);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weff_reg <= PW'(RST_WIDTH);
            heff_reg <= PW'(enms_pkg::IMG_H_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                enms_pkg::REG_IMAGE_WIDTH:  weff_reg <= clamp_w;
                enms_pkg::REG_IMAGE_HEIGHT: heff_reg <= clamp_h;
                default: ;
            endcase
        end
    end

    // handshake
    logic s_accept;
    logic adv;
    logic a_valid_reg;
    logic m_valid_reg;

    assign adv      = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !a_valid_reg || adv;
    assign s_accept = s_valid && s_ready;

    // position counters
    logic [CW-1:0]                 col_reg;
    logic [enms_pkg::ROW_W-1:0]    row_reg;
    logic [CW-1:0]                 col_next;
    logic [enms_pkg::ROW_W-1:0]    row_next;
    logic [PW-1:0] c0x, r0x, c1x, r1x, r2x, cnx, rnx;

    always_comb begin
        c0x = s_data.frame_start ? '0 : PW'(col_reg);
        r0x = s_data.frame_start ? '0 : PW'(row_reg);
        if (c0x >= weff_reg) begin
            c1x = '0;
            r1x = r0x + ONE_P;
        end else begin
            c1x = c0x;
            r1x = r0x;
        end
        r2x = (r1x >= heff_reg) ? '0 : r1x;
        cnx = c1x + ONE_P;
        rnx = r2x + ONE_P;
        if (cnx >= weff_reg) begin
            col_next = '0;
            row_next = (rnx >= heff_reg) ? '0 : rnx[enms_pkg::ROW_W-1:0];
        end else begin
            col_next = cnx[CW-1:0];
            row_next = r2x[enms_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input stage
    logic [enms_pkg::MAG_W-1:0] a_mag_reg;
    logic [enms_pkg::DIR_W-1:0] a_dir_reg;
    logic [CW-1:0]              a_c_reg;
    logic                       a_int_reg;
    logic                       a_last_reg;
    logic [enms_pkg::ROW_W-1:0] a_row_reg;
    logic [enms_pkg::COL_W-1:0] a_col_reg;
    logic                       a_byp_reg;
    enms_pkg::line_t            a_fwd_reg;
    enms_pkg::line_t            ram_rd;
    enms_pkg::line_t            line_eff;
    enms_pkg::line_t            line_wr;
    logic [PW-1:0]              orow_x;
    logic [PW-1:0]              ocol_x;

    assign orow_x   = r2x - ONE_P;
    assign ocol_x   = c1x - ONE_P;
    assign line_eff = a_byp_reg ? a_fwd_reg : ram_rd;
    assign line_wr  = '{upper: line_eff.mid, mid: a_mag_reg, dir: a_dir_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_byp_reg   <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
            a_byp_reg   <= adv && (a_c_reg == c1x[CW-1:0]);
        end else if (adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_mag_reg  <= s_data.magnitude;
            a_dir_reg  <= s_data.direction;
            a_c_reg    <= c1x[CW-1:0];
            a_int_reg  <= (r2x >= TWO_P) && (c1x >= TWO_P);
            a_last_reg <= (r2x == heff_reg - ONE_P) && (c1x == weff_reg - ONE_P);
            a_row_reg  <= orow_x[enms_pkg::ROW_W-1:0];
            a_col_reg  <= ocol_x[enms_pkg::COL_W-1:0];
            a_fwd_reg  <= line_wr;
        end
    end

    enms_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH ($bits(enms_pkg::line_t))
    ) u_line_ram (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (c1x[CW-1:0]),
        .rd_data (ram_rd),
        .wr_en   (adv),
        .wr_addr (a_c_reg),
        .wr_data (line_wr)
    );

    // window and result stage
    enms_pkg::col_t             win0_reg;
    enms_pkg::col_t             win1_reg;
    logic [enms_pkg::DIR_W-1:0] cdir_reg;
    enms_pkg::col_t             newcol;
    logic [enms_pkg::MAG_W-1:0] nms_value;
    enms_pkg::out_t             m_data_reg;

    assign newcol = '{top: line_eff.upper, mid: line_eff.mid, bot: a_mag_reg};

    enms_nms_core u_nms_core (
        .left       (win1_reg),
        .centre     (win0_reg),
        .right      (newcol),
        .centre_dir (cdir_reg),
        .value      (nms_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg    <= '0;
            win1_reg    <= '0;
            cdir_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                win1_reg    <= win0_reg;
                win0_reg    <= newcol;
                cdir_reg    <= line_eff.dir;
                m_valid_reg <= a_int_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && a_int_reg) begin
            m_data_reg <= '{suppressed_value: nms_value, out_row: a_row_reg,
                            out_col: a_col_reg, frame_last: a_last_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_NEXT(a_interior_emits, aclk, aresetn, adv && a_int_reg, m_valid_reg, "interior pixel lost")
    `ASSERT_NEXT(a_bypass_only_b2b, aclk, aresetn, s_accept && !adv, !a_byp_reg, "bad RAM bypass")
    `ASSERT_IMPL(a_row_interior, aclk, aresetn, m_valid_reg, m_data_reg.out_row != '0, "border row out")

endmodule
